// File: sv/mcsf_pkg.sv
`timescale 1ns / 1ps

package mcsf_pkg;

    localparam int MAX_RADIUS = 15;
    localparam int MAX_SPANS  = 48;
    localparam int MAX_ITER   = MAX_SPANS / 4;

    localparam int CENTRE_W = 12;
    localparam int RADIUS_W = 4;
    localparam int COLOUR_W = 24;
    localparam int COORD_W  = 13;
    localparam int X_W      = 6;
    localparam int D_W      = 8;
    localparam int ITER_W   = $clog2(MAX_ITER);
    localparam int STEP_W   = 3;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_SPAN0 = 3'd1;
    localparam step_t STEP_SPAN1 = 3'd2;
    localparam step_t STEP_SPAN2 = 3'd3;
    localparam step_t STEP_SPAN3 = 3'd4;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_LOOP
    } cond_t;

    typedef struct packed {
        logic       take;
        logic       emit;
        logic [1:0] span_sel;
        logic       calc_done;
        logic       commit;
        logic       last;
        cond_t      cond;
        step_t      target;
    } uword_t;

    typedef struct packed {
        logic       load;
        logic       fire;
        logic [1:0] span_sel;
        logic       calc_done;
        logic       commit;
        logic       last;
    } dp_ctrl_t;

    typedef struct packed {
        logic done;
    } dp_stat_t;

    function automatic uword_t ucode_rom(step_t step);
        uword_t w;
        w = '{take: 1'b0, emit: 1'b0, span_sel: 2'd0, calc_done: 1'b0, commit: 1'b0,
              last: 1'b0, cond: COND_NEXT, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:
            begin
                w.take = 1'b1;
                w.cond = COND_WAIT_IN;
            end
            STEP_SPAN0:
            begin
                w.emit     = 1'b1;
                w.span_sel = 2'd0;
            end
            STEP_SPAN1:
            begin
                w.emit     = 1'b1;
                w.span_sel = 2'd1;
            end
            STEP_SPAN2:
            begin
                w.emit      = 1'b1;
                w.span_sel  = 2'd2;
                w.calc_done = 1'b1;
            end
            STEP_SPAN3:
            begin
                w.emit     = 1'b1;
                w.span_sel = 2'd3;
                w.commit   = 1'b1;
                w.last     = 1'b1;
                w.cond     = COND_LOOP;
                w.target   = STEP_SPAN0;
            end
            default:
            begin
                w.cond = COND_NEXT;
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/mcsf_datapath.sv
`timescale 1ns / 1ps

module mcsf_datapath
    import mcsf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_ctrl_t                   ctrl,
    input  logic signed [CENTRE_W-1:0] centre_x,
    input  logic signed [CENTRE_W-1:0] centre_y,
    input  logic        [RADIUS_W-1:0] radius,
    input  logic        [COLOUR_W-1:0] colour,
    output dp_stat_t                   stat,
    output logic signed [COORD_W-1:0]  span_row,
    output logic signed [COORD_W-1:0]  span_left,
    output logic signed [COORD_W-1:0]  span_right,
    output logic        [COLOUR_W-1:0] span_colour,
    output logic                       last_span
);

    logic signed [CENTRE_W-1:0] cx_reg, cy_reg;
    logic        [COLOUR_W-1:0] colour_reg;
    logic signed [X_W-1:0]      x_reg, y_reg;
    logic signed [D_W-1:0]      d_reg;
    logic        [ITER_W-1:0]   iter_reg;
    logic                       done_reg;

    logic signed [COORD_W-1:0]  row_reg, left_reg, right_reg;
    logic        [COLOUR_W-1:0] scol_reg;
    logic                       last_reg;

    logic        [RADIUS_W-1:0] r_sat;
    logic signed [X_W-1:0]      y_init;
    logic signed [D_W-1:0]      d_init;
    logic signed [X_W-1:0]      x_next, y_next, diff;
    logic signed [D_W-1:0]      d_next;
    logic                       done_next;

    logic signed [X_W-1:0]      row_off, col_off;
    logic signed [COORD_W-1:0]  row_ext, col_ext, cx_ext, cy_ext;
    logic signed [COORD_W-1:0]  row_val, left_val, right_val;

    always_comb
    begin
        r_sat  = (radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius;
        y_init = signed'({{(X_W-RADIUS_W){1'b0}}, r_sat});
        d_init = signed'(D_W'(1)) - signed'({{(D_W-RADIUS_W){1'b0}}, r_sat});

        // one walk step: advance x, drop y when the decision is not negative
        x_next = x_reg + signed'(X_W'(1));
        if (d_reg[D_W-1])
        begin
            y_next = y_reg;
            diff   = x_next;
        end
        else
        begin
            y_next = y_reg - signed'(X_W'(1));
            diff   = x_next - y_next;
        end
        d_next    = d_reg + signed'({{(D_W-X_W-1){diff[X_W-1]}}, diff, 1'b1});
        done_next = (y_next < x_next) || (iter_reg == ITER_W'(MAX_ITER - 1));

        // span forms: bit 1 swaps x and y, bit 0 mirrors the row
        row_off   = ctrl.span_sel[1] ? x_reg : y_reg;
        col_off   = ctrl.span_sel[1] ? y_reg : x_reg;
        row_ext   = signed'({{(COORD_W-X_W){row_off[X_W-1]}}, row_off});
        col_ext   = signed'({{(COORD_W-X_W){col_off[X_W-1]}}, col_off});
        cx_ext    = signed'({{(COORD_W-CENTRE_W){cx_reg[CENTRE_W-1]}}, cx_reg});
        cy_ext    = signed'({{(COORD_W-CENTRE_W){cy_reg[CENTRE_W-1]}}, cy_reg});
        row_val   = ctrl.span_sel[0] ? (cy_ext - row_ext) : (cy_ext + row_ext);
        left_val  = cx_ext - col_ext;
        right_val = cx_ext + col_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            iter_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.calc_done && ctrl.fire)
            begin
                done_reg <= done_next;
            end
            if (ctrl.commit && ctrl.fire)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cx_reg     <= centre_x;
            cy_reg     <= centre_y;
            colour_reg <= colour;
            x_reg      <= '0;
            y_reg      <= y_init;
            d_reg      <= d_init;
        end
        else if (ctrl.commit && ctrl.fire)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            d_reg <= d_next;
        end

        if (ctrl.fire)
        begin
            row_reg   <= row_val;
            left_reg  <= left_val;
            right_reg <= right_val;
            scol_reg  <= colour_reg;
            last_reg  <= ctrl.last & done_reg;
        end
    end

    assign stat.done   = done_reg;
    assign span_row    = row_reg;
    assign span_left   = left_reg;
    assign span_right  = right_reg;
    assign span_colour = scol_reg;
    assign last_span   = last_reg;

endmodule

// File: sv/midpoint_circle_span_fill.sv
`timescale 1ns / 1ps
// Filled circle span generator.
// Input channel (in_valid / in_stall) takes one circle request: centre_x,
// centre_y, radius and colour. Output channel (out_valid / out_stall) gives
// the horizontal spans of the filled circle, four per step of the midpoint
// walk, each with the request colour; last_span marks the final one.
// A request of radius r gives 4 * (walk steps) spans, 44 at radius 15.
// Timing: a request is taken in the idle step, the first span is loaded in the
// step that follows and shows on the output in the cycle after; then one span
// per cycle while out_stall is low. The rate is set by the microcode
// sequencer: one control word per cycle while out_stall is low, one span per
// span step's control word, a single output register.
// in_stall is high from the cycle after a request is taken until the last
// span has been loaded into the output register.
// While out_stall is high and a span is waiting, the output register holds
// that span and the sequencer waits on its current span step.
// Reset clears the step counter and the output valid; a request in progress
// is dropped, and no new request is started by reset.

module midpoint_circle_span_fill
    import mcsf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [CENTRE_W-1:0] centre_x,
    input  logic signed [CENTRE_W-1:0] centre_y,
    input  logic        [RADIUS_W-1:0] radius,
    input  logic        [COLOUR_W-1:0] colour,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  span_row,
    output logic signed [COORD_W-1:0]  span_left,
    output logic signed [COORD_W-1:0]  span_right,
    output logic        [COLOUR_W-1:0] span_colour,
    output logic                       last_span
);

    step_t    step_reg, step_next;
    logic     out_valid_reg, out_valid_next;
    uword_t   uw;
    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic     slot_free;
    logic     fire;

    assign uw        = ucode_rom(step_reg);
    assign slot_free = !out_valid_reg || !out_stall;
    assign fire      = uw.emit && slot_free;
    assign in_stall  = !uw.take;

    always_comb
    begin
        ctrl.load      = uw.take && in_valid;
        ctrl.fire      = fire;
        ctrl.span_sel  = uw.span_sel;
        ctrl.calc_done = uw.calc_done;
        ctrl.commit    = uw.commit;
        ctrl.last      = uw.last;

        step_next = step_reg;
        unique case (uw.cond)
            COND_WAIT_IN:
            begin
                if (in_valid)
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            COND_LOOP:
            begin
                if (fire)
                begin
                    step_next = stat.done ? STEP_IDLE : uw.target;
                end
            end
            default:
            begin
                if (!uw.emit || fire)
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
        endcase

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    mcsf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .centre_x    (centre_x),
        .centre_y    (centre_y),
        .radius      (radius),
        .colour      (colour),
        .stat        (stat),
        .span_row    (span_row),
        .span_left   (span_left),
        .span_right  (span_right),
        .span_colour (span_colour),
        .last_span   (last_span)
    );

endmodule

// File: sv/mcsf_checker.sv
`timescale 1ns / 1ps

module mcsf_checker
    import mcsf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [COORD_W-1:0]  span_row,
    input  logic signed [COORD_W-1:0]  span_left,
    input  logic signed [COORD_W-1:0]  span_right,
    input  logic        [COLOUR_W-1:0] span_colour,
    input  logic                       last_span
);

    // a waiting span holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(span_row) && $stable(span_left)
            && $stable(span_right) && $stable(span_colour) && $stable(last_span))
        else $error("span changed while stalled");

    // a span never runs right to left
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> span_left <= span_right)
        else $error("span left beyond right");

    // a taken request blocks the next one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while circle still in progress");

    // more spans follow anything but the last one
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_span |-> in_stall)
        else $error("request taken before last span");

endmodule

bind midpoint_circle_span_fill mcsf_checker u_mcsf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .span_row    (span_row),
    .span_left   (span_left),
    .span_right  (span_right),
    .span_colour (span_colour),
    .last_span   (last_span)
);
